// File: sv/hs_pkg.sv
// ----------------------------------------------------------------------------
// hs_pkg
// Shared constants and types of the heap sorter: store size, data width,
// controller states, datapath operations and the status bundle.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int HS_DEPTH = 64;
    localparam int HS_DW    = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_SELECT,
        ST_FETCH,
        ST_GRAB,
        ST_READ,
        ST_CMP,
        ST_OREAD,
        ST_OLOAD
    } hs_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PREP,
        OP_SELECT,
        OP_FETCH,
        OP_GRAB,
        OP_READ,
        OP_CMP,
        OP_OREAD,
        OP_OLOAD
    } hs_op_t;

    typedef struct packed {
        hs_op_t op;
    } hs_cmd_t;

    typedef struct packed {
        logic set_end;
        logic build_go;
        logic build_end;
        logic ext_go;
        logic leaf;
        logic sift_done;
        logic out_free;
        logic out_last_idx;
    } hs_status_t;

endpackage

// File: sv/hs_ram.sv
// ----------------------------------------------------------------------------
// hs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: sv/hs_ctrl.sv
// ----------------------------------------------------------------------------
// hs_ctrl
// Sequencer of the heap sorter: load, heap build, extraction, read-out.
// ----------------------------------------------------------------------------
module hs_ctrl
    import hs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hs_status_t status,
    output hs_cmd_t    cmd,
    output logic       in_stall
);

    hs_state_t state_reg;
    hs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.op   = OP_LOAD;
                in_stall = 1'b0;
                if (status.set_end)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                cmd.op = OP_SELECT;
                priority if (status.build_go)
                begin
                    state_next = ST_FETCH;
                end
                else if (status.build_end)
                begin
                    state_next = ST_SELECT;
                end
                else if (status.ext_go)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_OREAD;
                end
            end
            ST_FETCH:
            begin
                cmd.op     = OP_FETCH;
                state_next = ST_GRAB;
            end
            ST_GRAB:
            begin
                cmd.op     = OP_GRAB;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.op     = OP_READ;
                state_next = status.leaf ? ST_SELECT : ST_CMP;
            end
            ST_CMP:
            begin
                cmd.op     = OP_CMP;
                state_next = status.sift_done ? ST_SELECT : ST_READ;
            end
            ST_OREAD:
            begin
                cmd.op = OP_OREAD;
                if (status.out_free)
                begin
                    state_next = ST_OLOAD;
                end
            end
            ST_OLOAD:
            begin
                cmd.op     = OP_OLOAD;
                state_next = status.out_last_idx ? ST_LOAD : ST_OREAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: sv/hs_dp.sv
// ----------------------------------------------------------------------------
// hs_dp
// Datapath of the heap sorter: element store, counters, sift-down compare
// and the output register.
// ----------------------------------------------------------------------------
module hs_dp
    import hs_pkg::*;
#(
    parameter int DEPTH = HS_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hs_cmd_t                 cmd,
    output hs_status_t              status,
    input  logic                    in_valid,
    input  logic signed [HS_DW-1:0] value,
    input  logic                    last,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic signed [HS_DW-1:0] value_res,
    output logic                    last_res,
    output logic                    overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [CW-1:0]           count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [CW-1:0]           size_reg, size_next;
    logic                    build_reg, build_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [CW-1:0]           heap_reg, heap_next;
    logic [AW-1:0]           node_reg, node_next;
    logic signed [HS_DW-1:0] nval_reg, nval_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    ov_valid_reg, ov_valid_next;
    logic signed [HS_DW-1:0] ov_value_reg, ov_value_next;
    logic                    ov_last_reg, ov_last_next;
    logic                    ov_ovf_reg, ov_ovf_next;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic [HS_DW-1:0]        wdata;
    logic [AW-1:0]           raddr_a, raddr_b;
    logic [HS_DW-1:0]        rdata_a, rdata_b;

    logic                    accept;
    logic                    full;
    logic [CW-1:0]           k_m1;
    logic [AW-1:0]           k_m1_a;
    logic [CW-1:0]           left;
    logic [CW-1:0]           right;
    logic                    left_in, right_in;
    logic signed [HS_DW-1:0] rd_l, rd_r, best;
    logic                    l_big, r_big;
    logic [AW-1:0]           top_addr;

    hs_ram #(
        .WIDTH (HS_DW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign accept   = in_valid && (cmd.op == OP_LOAD);
    assign full     = (count_reg == CW'(DEPTH));
    assign k_m1     = k_reg - CW'(1);
    assign k_m1_a   = k_m1[AW-1:0];
    assign left     = {node_reg, 1'b1};
    assign right    = left + CW'(1);
    assign left_in  = (left < heap_reg);
    assign right_in = (right < heap_reg);
    assign rd_l     = $signed(rdata_a);
    assign rd_r     = $signed(rdata_b);
    assign l_big    = left_in && (rd_l > nval_reg);
    assign best     = l_big ? rd_l : nval_reg;
    assign r_big    = right_in && (rd_r > best);
    assign top_addr = r_big ? right[AW-1:0] : left[AW-1:0];

    always_comb
    begin
        status.set_end      = accept && last;
        status.build_go     = build_reg && (k_reg != '0);
        status.build_end    = build_reg && (k_reg == '0);
        status.ext_go       = !build_reg && (k_reg > CW'(1));
        status.leaf         = !left_in;
        status.sift_done    = !l_big && !r_big;
        status.out_free     = !ov_valid_reg || !out_stall;
        status.out_last_idx = ({1'b0, idx_reg} == (size_reg - CW'(1)));
    end

    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        size_next     = size_reg;
        build_next    = build_reg;
        k_next        = k_reg;
        heap_next     = heap_reg;
        node_next     = node_reg;
        nval_next     = nval_reg;
        idx_next      = idx_reg;
        ov_valid_next = ov_valid_reg;
        ov_value_next = ov_value_reg;
        ov_last_next  = ov_last_reg;
        ov_ovf_next   = ov_ovf_reg;
        we            = 1'b0;
        waddr         = node_reg;
        wdata         = nval_reg;
        raddr_a       = idx_reg;
        raddr_b       = k_m1_a;

        if (ov_valid_reg && !out_stall)
        begin
            ov_valid_next = 1'b0;
        end

        unique case (cmd.op)
            OP_IDLE:
            begin
            end
            OP_LOAD:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[AW-1:0];
                        wdata      = value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            OP_PREP:
            begin
                size_next  = count_reg;
                k_next     = count_reg >> 1;
                build_next = 1'b1;
                idx_next   = '0;
            end
            OP_SELECT:
            begin
                if (status.build_end)
                begin
                    build_next = 1'b0;
                    k_next     = size_reg;
                end
            end
            OP_FETCH:
            begin
                raddr_a   = build_reg ? k_m1_a : '0;
                raddr_b   = k_m1_a;
                heap_next = build_reg ? size_reg : k_m1;
                node_next = build_reg ? k_m1_a : '0;
            end
            OP_GRAB:
            begin
                nval_next = build_reg ? rd_l : rd_r;
                if (!build_reg)
                begin
                    // old root goes to the end of the shrinking heap
                    we    = 1'b1;
                    waddr = k_m1_a;
                    wdata = rdata_a;
                end
            end
            OP_READ:
            begin
                raddr_a = left[AW-1:0];
                raddr_b = right[AW-1:0];
                if (!left_in)
                begin
                    we     = 1'b1;
                    k_next = k_m1;
                end
            end
            OP_CMP:
            begin
                we = 1'b1;
                if (status.sift_done)
                begin
                    k_next = k_m1;
                end
                else
                begin
                    wdata     = r_big ? rdata_b : rdata_a;
                    node_next = top_addr;
                end
            end
            OP_OREAD:
            begin
                raddr_a = idx_reg;
            end
            OP_OLOAD:
            begin
                ov_value_next = rd_l;
                ov_last_next  = status.out_last_idx;
                ov_ovf_next   = ovf_reg;
                ov_valid_next = 1'b1;
                idx_next      = idx_reg + AW'(1);
                if (status.out_last_idx)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            size_reg     <= '0;
            build_reg    <= 1'b0;
            k_reg        <= '0;
            heap_reg     <= '0;
            node_reg     <= '0;
            idx_reg      <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            size_reg     <= size_next;
            build_reg    <= build_next;
            k_reg        <= k_next;
            heap_reg     <= heap_next;
            node_reg     <= node_next;
            idx_reg      <= idx_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nval_reg     <= nval_next;
        ov_value_reg <= ov_value_next;
        ov_last_reg  <= ov_last_next;
        ov_ovf_reg   <= ov_ovf_next;
    end

    assign out_valid = ov_valid_reg;
    assign value_res = ov_value_reg;
    assign last_res  = ov_last_reg;
    assign overflow  = ov_ovf_reg;

endmodule

// File: sv/heap_sorter_core.sv
// Loading: one item per cycle while in_stall is low. A sort of n elements then runs about
//   3n/2 sift passes (select, fetch, grab, then read and compare per heap level), and
//   each result is then read from the store into an output register that holds under
//   out_stall. The sift loop reads both children of a node through the two read ports.
// Reset: asynchronous, active low; clears control and counters. Store contents are
//   undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
// heap_sorter_core
// Heap sorter: collects a set of signed values, heap-sorts it in a local
// store and returns it in ascending order with last and overflow marks.
// ----------------------------------------------------------------------------
module heap_sorter_core
    import hs_pkg::*;
#(
    parameter int DEPTH = HS_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [HS_DW-1:0] value,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [HS_DW-1:0] value_res,
    output logic                    last_res,
    output logic                    overflow
);

    hs_cmd_t    cmd;
    hs_status_t status;

    hs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    hs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (in_valid),
        .value     (value),
        .last      (last),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .value_res (value_res),
        .last_res  (last_res),
        .overflow  (overflow)
    );

endmodule

// File: sv/hs_checker.sv
// ----------------------------------------------------------------------------
// hs_checker
// Port-level checks of the heap sorter, bound to the top level.
// ----------------------------------------------------------------------------
module hs_checker
    import hs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    last,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [HS_DW-1:0] value_res,
    input logic                    last_res,
    input logic                    overflow
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_res)
            && $stable(last_res) && $stable(overflow))
        else $error("stalled result changed");

    // a set's last item starts the sort
    a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input taken right after end of set");

    // no input during read-out
    a_no_load_midset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_res |=> in_stall)
        else $error("input taken while results remain");

    // nothing follows the last result until a new set
    a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_res |=> !out_valid)
        else $error("result after end of set");

endmodule

bind heap_sorter_core hs_checker u_hs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for heap_sorter_core: sends sets of signed values,
// some past the store size, and checks every sorted result, its last mark
// and its overflow mark against a heap sort kept in the bench (or a fixed
// value for single-element sets), with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top
    import hs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 388;
    localparam int SETTLE_CYCLES = 200;
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic signed [HS_DW-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [HS_DW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [HS_DW-1:0] VAL_NEG1 = 32'shffff_ffff;

    typedef enum int {
        VALS_WIDE,
        VALS_NARROW,
        VALS_CORNER
    } val_mix_t;

    typedef struct packed {
        logic signed [HS_DW-1:0] val;
        logic                    fin;
        logic                    ovf;
    } sorted_elem_t;

    typedef struct {
        logic signed [HS_DW-1:0] val;
        logic                    fin;
        bit                      fixed_exp;
        logic signed [HS_DW-1:0] exp_val;
    } stim_row_t;

    localparam int DIR_ROWS = 22;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [HS_DW-1:0] value = '0;
    logic                    last = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [HS_DW-1:0] value_res;
    logic                    last_res;
    logic                    overflow;

    // bench copy of the sorter state
    logic signed [HS_DW-1:0] heap_mem [HS_DEPTH];
    int unsigned             fill_cnt = 0;
    bit                      dropped_seen = 1'b0;

    sorted_elem_t            fresh_sorted[$];
    sorted_elem_t            sorted_due[$];

    bit                      tx_quiet = 1'b0;
    bit                      rx_quiet = 1'b0;
    int unsigned             stall_left = 0;

    int unsigned             mismatches = 0;
    int unsigned             results_seen = 0;
    int unsigned             items_sent = 0;
    int unsigned             sets_done = 0;
    int unsigned             ovf_sets = 0;
    int unsigned             biggest_set = 0;

    stim_row_t               dir_rows [DIR_ROWS];

    heap_sorter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_res (value_res),
        .last_res  (last_res),
        .overflow  (overflow)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned pick_idle(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [HS_DW-1:0] pick_value(val_mix_t mix);
        logic signed [HS_DW-1:0] v;
        v = $urandom;
        if (mix == VALS_NARROW)
        begin
            v = $urandom_range(0, 7);
            v = v - 4;
        end
        else if (mix == VALS_CORNER)
        begin
            case ($urandom_range(0, 4))
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = '0;
                3: v = VAL_NEG1;
                default: v = $urandom;
            endcase
        end
        return v;
    endfunction

    task automatic sift_heap(input int unsigned start, input int unsigned size);
        int unsigned node;
        int unsigned big;
        int unsigned lc;
        int unsigned rc;
        logic signed [HS_DW-1:0] tmp;
        bit settled;
        node = start;
        settled = 1'b0;
        while (!settled)
        begin
            big = node;
            lc = 2 * node + 1;
            rc = 2 * node + 2;
            if (lc < size && heap_mem[lc] > heap_mem[big])
                big = lc;
            if (rc < size && heap_mem[rc] > heap_mem[big])
                big = rc;
            if (big == node)
                settled = 1'b1;
            else
            begin
                tmp = heap_mem[node];
                heap_mem[node] = heap_mem[big];
                heap_mem[big] = tmp;
                node = big;
            end
        end
    endtask

    task automatic heap_sort_set(input int unsigned size);
        int unsigned k;
        logic signed [HS_DW-1:0] tmp;
        for (k = size / 2; k > 0; k--)
            sift_heap(k - 1, size);
        for (k = size; k > 1; k--)
        begin
            tmp = heap_mem[0];
            heap_mem[0] = heap_mem[k - 1];
            heap_mem[k - 1] = tmp;
            sift_heap(0, k - 1);
        end
    endtask

    // store or drop one accepted item; on the last one, sort and list the set
    task automatic absorb_item(input logic signed [HS_DW-1:0] v, input logic fin);
        int unsigned k;
        fresh_sorted.delete();
        if (fill_cnt < HS_DEPTH)
        begin
            heap_mem[fill_cnt] = v;
            fill_cnt++;
        end
        else
            dropped_seen = 1'b1;
        if (fin)
        begin
            heap_sort_set(fill_cnt);
            for (k = 0; k < fill_cnt; k++)
                fresh_sorted.push_back('{heap_mem[k], k + 1 == fill_cnt, dropped_seen});
            sets_done++;
            if (dropped_seen)
                ovf_sets++;
            if (fill_cnt > biggest_set)
                biggest_set = fill_cnt;
            fill_cnt = 0;
            dropped_seen = 1'b0;
        end
    endtask

    task automatic send_item(input logic signed [HS_DW-1:0] v, input logic fin,
                             input bit fixed_exp, input logic signed [HS_DW-1:0] exp_val);
        int unsigned gap;
        gap = pick_idle(tx_quiet);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        absorb_item(v, fin);
        if (fixed_exp)
            sorted_due.push_back('{exp_val, 1'b1, 1'b0});
        else
            foreach (fresh_sorted[i])
                sorted_due.push_back(fresh_sorted[i]);
    endtask

    // output side: random stalls and result checking
    always @(posedge clk)
    begin : rx_side
        int unsigned n;
        sorted_elem_t want;
        if ($urandom_range(0, 127) == 0)
            rx_quiet <= ($urandom_range(0, 3) == 0);
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            n = pick_idle(rx_quiet);
            out_stall <= (n != 0);
            if (n != 0)
                stall_left <= n - 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (sorted_due.size() == 0)
            begin
                if (mismatches < SHOWN_MISMATCHES)
                    $display("%0t: unexpected result value %0d last %0b overflow %0b",
                             $realtime, value_res, last_res, overflow);
                mismatches++;
            end
            else
            begin
                want = sorted_due.pop_front();
                if (value_res !== want.val || last_res !== want.fin || overflow !== want.ovf)
                begin
                    if (mismatches < SHOWN_MISMATCHES)
                        $display("%0t: result %0d expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 $realtime, results_seen, want.val, want.fin, want.ovf,
                                 value_res, last_res, overflow);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("heap_sorter_core verification failed");
        $finish;
    end

    initial
    begin : stim_main
        int unsigned rand_items;
        int unsigned set_no;
        int unsigned len;
        val_mix_t mix;

        // single-element sets, known by eye
        dir_rows[0]  = '{VAL_MAX, 1'b1, 1'b1, VAL_MAX};
        dir_rows[1]  = '{VAL_MIN, 1'b1, 1'b1, VAL_MIN};
        dir_rows[2]  = '{32'sd0, 1'b1, 1'b1, 32'sd0};
        dir_rows[3]  = '{VAL_NEG1, 1'b1, 1'b1, VAL_NEG1};
        // mixed signs, a duplicate, both extremes
        dir_rows[4]  = '{32'sd5, 1'b0, 1'b0, '0};
        dir_rows[5]  = '{VAL_NEG1, 1'b0, 1'b0, '0};
        dir_rows[6]  = '{32'sd5, 1'b0, 1'b0, '0};
        dir_rows[7]  = '{VAL_MIN, 1'b0, 1'b0, '0};
        dir_rows[8]  = '{VAL_MAX, 1'b0, 1'b0, '0};
        dir_rows[9]  = '{32'sd0, 1'b0, 1'b0, '0};
        dir_rows[10] = '{32'sd1, 1'b1, 1'b0, '0};
        // two elements, reversed
        dir_rows[11] = '{VAL_MAX, 1'b0, 1'b0, '0};
        dir_rows[12] = '{VAL_MIN, 1'b1, 1'b0, '0};
        // all equal
        dir_rows[13] = '{32'sh1234_5678, 1'b0, 1'b0, '0};
        dir_rows[14] = '{32'sh1234_5678, 1'b0, 1'b0, '0};
        dir_rows[15] = '{32'sh1234_5678, 1'b1, 1'b0, '0};
        // alternating bit patterns
        dir_rows[16] = '{32'shaaaa_aaaa, 1'b0, 1'b0, '0};
        dir_rows[17] = '{32'sh5555_5555, 1'b1, 1'b0, '0};
        // already ascending
        dir_rows[18] = '{-32'sd2, 1'b0, 1'b0, '0};
        dir_rows[19] = '{VAL_NEG1, 1'b0, 1'b0, '0};
        dir_rows[20] = '{32'sd0, 1'b0, 1'b0, '0};
        dir_rows[21] = '{32'sd1, 1'b1, 1'b0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].val, dir_rows[i].fin, dir_rows[i].fixed_exp,
                      dir_rows[i].exp_val);

        // random sets; a full one and two that overrun the store are mixed in
        rand_items = 0;
        set_no = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if (set_no == 3)
                len = HS_DEPTH;
            else if (set_no == 8)
                len = HS_DEPTH + 1;
            else if (set_no == 14)
                len = HS_DEPTH + 2 + $urandom_range(0, 5);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 30);
            else
                len = $urandom_range(1, 12);
            tx_quiet = ($urandom_range(0, 4) == 0);
            mix = val_mix_t'($urandom_range(0, 2));
            for (int unsigned k = 0; k < len; k++)
                send_item(pick_value(mix), k + 1 == len, 1'b0, '0);
            rand_items += len;
            set_no++;
        end
        in_valid <= 1'b0;

        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items in %0d sets, largest %0d; %0d sets overran the store.",
                 items_sent, sets_done, biggest_set, ovf_sets);
        $display("Checked %0d sorted results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("heap_sorter_core verification clean");
        else
            $display("heap_sorter_core verification failed");
        $finish;
    end

endmodule

// File: files.f
sv/hs_pkg.sv
sv/hs_ram.sv
sv/hs_ctrl.sv
sv/hs_dp.sv
sv/heap_sorter_core.sv
sv/hs_checker.sv
dv/tb_top.sv
